// ===== design/dfsp_pkg.sv =====
// Shared types and constants for the delimited frame sensor parser.
package dfsp_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned POS_W       = 7;
	localparam int unsigned NUM_SENSORS = 8;

	localparam logic [POS_W-1:0] KIND_POS        = POS_W'(1);
	localparam int unsigned      FIRST_DIGIT_POS = 6;
	localparam int unsigned      DIGIT_STRIDE    = 5;

	localparam logic [BYTE_W-1:0] CH_START   = 8'h24;
	localparam logic [BYTE_W-1:0] CH_END     = 8'h23;
	localparam logic [BYTE_W-1:0] CH_DIGITAL = 8'h44;
	localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;

	typedef logic [NUM_SENSORS-1:0][BYTE_W-1:0] sensor_vec_t;

	typedef struct packed {
		logic [BYTE_W-1:0] kind;
		sensor_vec_t       digits;
	} frame_close_t;

endpackage

// ===== design/dfsp_if.sv =====
// Valid/ready channel interfaces for received bytes and frame results.
interface dfsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfsp_out_if;
	logic       valid;
	logic       ready;
	logic       updated;
	logic [7:0] sensor_0;
	logic [7:0] sensor_1;
	logic [7:0] sensor_2;
	logic [7:0] sensor_3;
	logic [7:0] sensor_4;
	logic [7:0] sensor_5;
	logic [7:0] sensor_6;
	logic [7:0] sensor_7;

	modport source (
		output valid, output updated,
		output sensor_0, output sensor_1, output sensor_2, output sensor_3,
		output sensor_4, output sensor_5, output sensor_6, output sensor_7,
		input ready
	);
	modport sink (
		input valid, input updated,
		input sensor_0, input sensor_1, input sensor_2, input sensor_3,
		input sensor_4, input sensor_5, input sensor_6, input sensor_7,
		output ready
	);
endinterface

// ===== design/dfsp_frame.sv =====
// Frame tracker: position counter, kind byte and digit capture per received word.
module dfsp_frame
	import dfsp_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              take,
	output logic              emit,
	output frame_close_t      close_ev
);

	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME);

	logic              open_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] kind_q;
	sensor_vec_t       digits_q;

	logic              store;
	logic              clear;
	logic [POS_W-1:0]  pos_n;
	logic [BYTE_W-1:0] kind_n;
	sensor_vec_t       digits_n;

	always_comb begin
		store    = (rx_byte == CH_START) || open_q;
		emit     = open_q && (rx_byte == CH_END);
		kind_n   = kind_q;
		digits_n = digits_q;
		pos_n    = pos_q;
		if (store) begin
			if (pos_q == KIND_POS) begin
				kind_n = rx_byte;
			end
			for (int i = 0; i < NUM_SENSORS; i++) begin
				if (pos_q == POS_W'(FIRST_DIGIT_POS + i * DIGIT_STRIDE)) begin
					digits_n[i] = rx_byte;
				end
			end
			pos_n = pos_q + POS_W'(1);
		end
		clear = emit || (store && (pos_n >= MAX_POS));
		close_ev.kind   = kind_n;
		close_ev.digits = digits_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			pos_q    <= '0;
			kind_q   <= '0;
			digits_q <= '0;
		end else if (take) begin
			if (clear) begin
				open_q   <= 1'b0;
				pos_q    <= '0;
				kind_q   <= '0;
				digits_q <= '0;
			end else begin
				open_q   <= store;
				pos_q    <= pos_n;
				kind_q   <= kind_n;
				digits_q <= digits_n;
			end
		end
	end

endmodule

// ===== design/dfsp_decode.sv =====
// Sensor decode and result register: refresh held values on digital frames while digital_enable is set.
module dfsp_decode
	import dfsp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         digital_enable,
	input  logic         ev_valid,
	input  frame_close_t ev,
	output logic         ev_ready,
	dfsp_out_if.source   res
);

	logic        valid_q;
	logic        updated_q;
	sensor_vec_t held_q;
	logic        load;
	logic        refresh;

	assign ev_ready = !valid_q || res.ready;
	assign load     = ev_valid && ev_ready;
	assign refresh  = digital_enable && (ev.kind == CH_DIGITAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			updated_q <= 1'b0;
			held_q    <= '0;
		end else begin
			if (load) begin
				valid_q   <= 1'b1;
				updated_q <= refresh;
				if (refresh) begin
					for (int i = 0; i < NUM_SENSORS; i++) begin
						held_q[i] <= ev.digits[i] - CH_ZERO;
					end
				end
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign res.valid    = valid_q;
	assign res.updated  = updated_q;
	assign res.sensor_0 = held_q[0];
	assign res.sensor_1 = held_q[1];
	assign res.sensor_2 = held_q[2];
	assign res.sensor_3 = held_q[3];
	assign res.sensor_4 = held_q[4];
	assign res.sensor_5 = held_q[5];
	assign res.sensor_6 = held_q[6];
	assign res.sensor_7 = held_q[7];

endmodule

// ===== design/delimited_frame_sensor_parser_core.sv =====
// Top level of the delimited frame sensor parser.
//
// Usage:
//   rx  : one received serial byte per word. A '$' opens a frame, '#' closes it.
//   res : one word per closed frame: updated flag and the eight held sensor values.
//   cfg_we/cfg_wdata : write digital_enable; write only while the block is idle.
// Path: a closing byte passes the input register, then the close-event register, then
//   the result register, before its result shows on res.
// Throughput: one byte per cycle, set by the frame tracker, unless a closing byte waits on a full close-event register.
// Bytes that produce no result never wait on res; a stalled res holds its
//   word, one further close event waits in the middle stage, and rx.ready
//   drops only when a second close event reaches the input register.
// A frame reaching MAX_FRAME positions is dropped with no result.
// Reset clears frame state, held values, digital_enable and all valid flags;
//   the block accepts bytes in the first cycle after reset is released.
module delimited_frame_sensor_parser_core
	import dfsp_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 100
) (
	input  logic       clk,
	input  logic       arst_n,
	dfsp_in_if.sink    rx,
	dfsp_out_if.source res,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	logic              en_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	frame_close_t      ev_s2;

	logic              emit;
	frame_close_t      close_ev;
	logic              take;
	logic              s2_ready;
	logic              s2_free;

	assign s2_free  = !valid_s2 || s2_ready;
	assign take     = valid_s1 && (!emit || s2_free);
	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
		end else if (cfg_we) begin
			en_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && take && emit) begin
			ev_s2 <= close_ev;
		end
	end

	dfsp_frame #(
		.MAX_FRAME(MAX_FRAME)
	) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (byte_s1),
		.take    (take),
		.emit    (emit),
		.close_ev(close_ev)
	);

	dfsp_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.digital_enable(en_q),
		.ev_valid      (valid_s2),
		.ev            (ev_s2),
		.ev_ready      (s2_ready),
		.res           (res)
	);

endmodule

// ===== design/dfsp_chk.sv =====
// Port-level checker for the parser core, bound to the top level.
module dfsp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_updated,
	input logic [7:0] sensor_0,
	input logic [7:0] sensor_1,
	input logic [7:0] sensor_2,
	input logic [7:0] sensor_3,
	input logic [7:0] sensor_4,
	input logic [7:0] sensor_5,
	input logic [7:0] sensor_6,
	input logic [7:0] sensor_7,
	input logic       cfg_we,
	input logic       cfg_wdata
);

	logic        en_q;
	logic [63:0] sensors;

	assign sensors = {sensor_7, sensor_6, sensor_5, sensor_4,
		sensor_3, sensor_2, sensor_1, sensor_0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
		end else if (cfg_we) begin
			en_q <= cfg_wdata;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_updated) && $stable(sensors))
		else $error("result word changed while stalled");

	a_update_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_updated |-> en_q)
		else $error("update reported with digital decoding disabled");

	a_values_change_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sensors) |-> res_valid && res_updated)
		else $error("held values changed without an updating result");

endmodule

bind delimited_frame_sensor_parser_core dfsp_chk u_dfsp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_updated(res.updated),
	.sensor_0   (res.sensor_0),
	.sensor_1   (res.sensor_1),
	.sensor_2   (res.sensor_2),
	.sensor_3   (res.sensor_3),
	.sensor_4   (res.sensor_4),
	.sensor_5   (res.sensor_5),
	.sensor_6   (res.sensor_6),
	.sensor_7   (res.sensor_7),
	.cfg_we     (cfg_we),
	.cfg_wdata  (cfg_wdata)
);

// ===== tb/sv/dfsp_frame_checker.sv =====
// Checker for the frame parser: predicts each frame result from accepted bytes and compares it.
module dfsp_frame_checker
	import dfsp_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 100
) (
	input  logic clk,
	input  logic arst_n,
	dfsp_in_if   rx,
	dfsp_out_if  res,
	input  logic cfg_we,
	input  logic cfg_wdata,
	output int   mismatches,
	output int   readings_due
);

	typedef struct packed {
		logic        updated;
		sensor_vec_t sensors;
	} reading_t;

	logic              decode_en;
	logic              in_frame;
	logic [POS_W-1:0]  position;
	logic [BYTE_W-1:0] kind;
	sensor_vec_t       digits;
	sensor_vec_t       held;
	reading_t          due_readings[$];
	int                bad = 0;

	assign mismatches = bad;

	task automatic clear_frame();
		in_frame = 1'b0;
		position = '0;
		kind     = '0;
		digits   = '0;
	endtask

	task automatic absorb_byte(input logic [BYTE_W-1:0] b);
		reading_t r;
		if (b != CH_START && !in_frame)
			return;
		in_frame = 1'b1;
		if (position == KIND_POS)
			kind = b;
		for (int i = 0; i < NUM_SENSORS; i++)
			if (position == FIRST_DIGIT_POS + i * DIGIT_STRIDE)
				digits[i] = b;
		position = position + 1'b1;
		if (b == CH_END) begin
			r.updated = decode_en && kind == CH_DIGITAL;
			if (r.updated)
				for (int i = 0; i < NUM_SENSORS; i++)
					held[i] = digits[i] - CH_ZERO;
			r.sensors = held;
			due_readings.push_back(r);
			clear_frame();
		end else if (position >= MAX_FRAME) begin
			clear_frame();
		end
	endtask

	task automatic compare_reading();
		reading_t    want;
		sensor_vec_t got;
		got = {res.sensor_7, res.sensor_6, res.sensor_5, res.sensor_4,
			res.sensor_3, res.sensor_2, res.sensor_1, res.sensor_0};
		if (due_readings.size() == 0) begin
			bad++;
			$display("%0t: unexpected result: expected none, actual updated %0b sensors %h",
				$time, res.updated, got);
			return;
		end
		want = due_readings.pop_front();
		if (res.updated !== want.updated) begin
			bad++;
			$display("%0t: updated mismatch: expected %0b, actual %0b",
				$time, want.updated, res.updated);
		end
		for (int i = 0; i < NUM_SENSORS; i++)
			if (got[i] !== want.sensors[i]) begin
				bad++;
				$display("%0t: sensor_%0d mismatch: expected %0d, actual %0d",
					$time, i, want.sensors[i], got[i]);
			end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_en = 1'b0;
			clear_frame();
			held = '0;
			due_readings.delete();
			readings_due <= 0;
		end else begin
			if (res.valid && res.ready)
				compare_reading();
			if (cfg_we)
				decode_en = cfg_wdata;
			if (rx.valid && rx.ready)
				absorb_byte(rx.rx_byte);
			readings_due <= due_readings.size();
		end
	end

endmodule

// ===== tb/sv/tb_delimited_frame_sensor_parser_core.sv =====
// Testbench top for the frame parser: drives bytes and configuration, reports the verdict.
module tb_delimited_frame_sensor_parser_core
	import dfsp_pkg::*;
();

	localparam int unsigned FRAME_LIMIT = 100;
	localparam int unsigned FULL_LEN    = FIRST_DIGIT_POS + (NUM_SENSORS - 1) * DIGIT_STRIDE + 1;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   mismatches;
	int   readings_due;
	logic calm         = 1'b0;
	int   tx_gap_pct   = 0;
	int   rx_stall_pct = 0;
	int   byte_count   = 0;
	int   frame_count  = 0;

	dfsp_in_if  rx_ch ();
	dfsp_out_if res_ch ();

	delimited_frame_sensor_parser_core #(.MAX_FRAME(FRAME_LIMIT)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	dfsp_frame_checker #(.MAX_FRAME(FRAME_LIMIT)) frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx_ch),
		.res         (res_ch),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.readings_due(readings_due)
	);

	always #5 clk = ~clk;

	always begin
		@(posedge clk);
		if (!calm && $urandom_range(1, 100) <= rx_stall_pct) begin
			res_ch.ready <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		res_ch.ready <= 1'b1;
	end

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	function automatic logic [7:0] digit_char();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom);
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] filler_char();
		logic [7:0] b;
		if ($urandom_range(0, 19) == 0)
			return CH_START;
		b = 8'($urandom);
		while (b == CH_END)
			b = 8'($urandom);
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		if (!calm && $urandom_range(1, 100) <= tx_gap_pct) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		byte_count++;
	endtask

	// len is the position of the closing byte; at FRAME_LIMIT the frame drops first
	task automatic send_frame(input logic [7:0] kind_b, input int unsigned len);
		send_byte(CH_START);
		for (int unsigned p = 1; p < len; p++) begin
			if (p == 1)
				send_byte(kind_b);
			else if (p >= FIRST_DIGIT_POS && p < FULL_LEN
					&& (p - FIRST_DIGIT_POS) % DIGIT_STRIDE == 0)
				send_byte(digit_char());
			else if (p == FRAME_LIMIT - 1 && $urandom_range(0, 1))
				send_byte(CH_START);
			else
				send_byte(filler_char());
		end
		send_byte(CH_END);
		frame_count++;
	endtask

	task automatic settle();
		rx_ch.valid <= 1'b0;
		do @(posedge clk); while (readings_due != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_digital(input logic en);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int start_bytes;
		int start_frames;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		tx_gap_pct   = 20;
		rx_stall_pct = 20;
		set_digital(1'b1);
		// bytes outside a frame
		send_byte(8'h41);
		send_byte(CH_END);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(8'h00, 1);
		send_frame(CH_DIGITAL, 2);
		send_byte(CH_START);
		send_byte(CH_DIGITAL);
		send_byte(CH_START);
		send_byte(CH_END);
		send_byte(CH_START);
		send_byte(CH_START);
		send_byte(CH_DIGITAL);
		send_byte(CH_END);
		send_frame(CH_DIGITAL, FIRST_DIGIT_POS);
		set_digital(1'b0);
		send_frame(CH_DIGITAL, 2);

		for (int ph = 0; ph < 6; ph++) begin
			set_digital(ph == 0 ? 1'b1 : ph == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
			tx_gap_pct   = pick_pct();
			rx_stall_pct = pick_pct();
			calm         = (ph == 5);
			start_bytes  = byte_count;
			start_frames = frame_count;
			while (byte_count - start_bytes < 140 || frame_count - start_frames < 4) begin
				case ($urandom_range(0, 15))
					0, 1: repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
					2: send_frame(CH_DIGITAL, $urandom_range(FRAME_LIMIT - 1, FRAME_LIMIT));
					3, 4: send_frame(8'($urandom), $urandom_range(1, 12));
					default: send_frame(
						($urandom_range(0, 9) != 0) ? CH_DIGITAL : 8'($urandom),
						($urandom_range(0, 9) < 7) ? FULL_LEN : $urandom_range(2, 60));
				endcase
			end
		end

		settle();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
